// ----- hdl/mfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// mfsa_pkg: shared types and constants
// Default sizes, command and status records for the fraction accumulator.
// ----------------------------------------------------------------------------
package mfsa_pkg;
    localparam int COUNT_BITS_DEF = 16;
    localparam int ACC_BITS_DEF   = 64;

    typedef struct packed {
        logic signed [15:0] whole_part;
        logic [14:0]        frac_numerator;
        logic [14:0]        frac_denominator;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] sum_whole;
        logic signed [63:0] sum_remainder;
        logic [62:0]        sum_denom;
        logic signed [63:0] avg_whole;
        logic signed [63:0] avg_remainder;
        logic [62:0]        avg_denom;
        logic               overflow_flag;
        logic               bad_denominator_flag;
    } t_out_item;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch item, form value magnitude
        OP_MUL1,      // t1 = |rn| * d
        OP_MUL2,      // t2 = vm * rd
        OP_MUL3,      // nd = rd * d
        OP_ADD,       // signed sum of t1 and t2
        OP_GCD_INIT,  // a = sm, b = nd
        OP_DIV_INIT,  // start a / b
        OP_DIV_STEP,  // one quotient bit
        OP_GCD_NEXT,  // a = b, b = rem
        OP_COMMIT,    // reduce and store running state
        OP_FIN_SUM,   // start split of the sum
        OP_AVG_GCD1,  // gcd(|rn|, count)
        OP_AVG_MUL,   // ad = rd * c
        OP_AVG_GCD2,  // gcd(am, ad)
        OP_FIN_AVG    // start split of the average
    } t_op;

    typedef struct packed {
        t_op  op;
        logic [1:0] sel;   // purpose of current division
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic b_zero;
        logic ok;
        logic last;
        logic dzero;
        logic cnt_zero;
    } t_stat;

    localparam logic [1:0] DV_GCD  = 2'd0;
    localparam logic [1:0] DV_RED  = 2'd1;
    localparam logic [1:0] DV_SPLT = 2'd2;
endpackage

// ----- hdl/mfsa_if.sv -----
// ----------------------------------------------------------------------------
// mfsa_stream_if: valid/ready channel
// Carries one payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface mfsa_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mfsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfsa_ctrl: sequencer
// Steps the datapath through multiply, add, gcd and split phases.
// ----------------------------------------------------------------------------
module mfsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mfsa_pkg::t_stat i_stat,
    output mfsa_pkg::t_cmd  o_cmd
);
    import mfsa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_M1   = 12'b000000000010,
        S_M2   = 12'b000000000100,
        S_M3   = 12'b000000001000,
        S_ADD  = 12'b000000010000,
        S_GCD  = 12'b000000100000,
        S_DIV  = 12'b000001000000,
        S_RED  = 12'b000010000000,
        S_FIN  = 12'b000100000000,
        S_AMUL = 12'b001000000000,
        S_AG2  = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_phase, n_phase; // which sub-job the divider serves
    logic [1:0] r_red, n_red;     // divide job: reductions 0 and 1, split 2, gcd 3
    logic       r_mwait, n_mwait; // set while a product finishes its high half

    // phase codes
    localparam logic [2:0] PH_ITEM = 3'd0, PH_SUM = 3'd1, PH_AG1 = 3'd2,
                           PH_AG2 = 3'd3, PH_AVG = 3'd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_ITEM;
            r_red   <= '0;
            r_mwait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_red   <= n_red;
            r_mwait <= n_mwait;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_red   = r_red;
        n_mwait = r_mwait;
        o_cmd.op  = OP_NONE;
        o_cmd.sel = DV_GCD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state = S_M1;
                    n_phase = PH_ITEM;
                end
            end
            S_M1: begin
                if (i_stat.dzero) begin
                    n_state = i_stat.last ? S_FIN : S_IDLE;
                    n_phase = PH_SUM;
                end else if (!r_mwait) begin
                    o_cmd.op = OP_MUL1;
                    n_mwait = 1'b1;
                end else begin
                    n_mwait = 1'b0;
                    n_state = S_M2;
                end
            end
            S_M2: begin
                if (!r_mwait) begin
                    o_cmd.op = OP_MUL2;
                    n_mwait = 1'b1;
                end else begin
                    n_mwait = 1'b0;
                    n_state = S_M3;
                end
            end
            S_M3: begin
                if (!r_mwait) begin
                    o_cmd.op = OP_MUL3;
                    n_mwait = 1'b1;
                end else begin
                    n_mwait = 1'b0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                n_state = S_GCD;
            end
            S_GCD: begin
                // gcd setup depends on phase
                if (r_phase == PH_ITEM) begin
                    if (!i_stat.ok) begin
                        o_cmd.op = OP_COMMIT;
                        n_state = i_stat.last ? S_FIN : S_IDLE;
                        n_phase = PH_SUM;
                    end else begin
                        o_cmd.op = OP_GCD_INIT;
                        n_state = S_RED;
                    end
                end else begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                // Euclid loop: divide until remainder is zero
                if (i_stat.b_zero) begin
                    o_cmd.op  = OP_DIV_INIT;
                    o_cmd.sel = DV_RED;
                    n_red = 2'd0;
                    n_state = S_DIV;
                end else begin
                    o_cmd.op  = OP_DIV_INIT;
                    o_cmd.sel = DV_GCD;
                    n_red = 2'd3;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                o_cmd.sel = (r_red == 2'd3) ? DV_GCD : DV_RED;
                if (i_stat.div_done) begin
                    if (r_red == 2'd3) begin
                        o_cmd.op = OP_GCD_NEXT;
                        n_state = S_RED;
                    end else if (r_red == 2'd0) begin
                        // first operand reduced, now second
                        o_cmd.op  = OP_DIV_INIT;
                        o_cmd.sel = DV_RED;
                        n_red = 2'd1;
                    end else begin
                        n_red = 2'd0;
                        case (r_phase)
                            PH_ITEM: begin
                                o_cmd.op = OP_COMMIT;
                                n_state = i_stat.last ? S_FIN : S_IDLE;
                                n_phase = PH_SUM;
                            end
                            PH_AG1: begin
                                o_cmd.op = OP_AVG_MUL;
                                n_state = S_AMUL;
                            end
                            PH_AG2: begin
                                o_cmd.op = OP_FIN_AVG;
                                n_state = S_DIV;
                                n_phase = PH_AVG;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_FIN: begin
                // sum split: one divider pass gives quotient and remainder
                if (r_phase == PH_SUM) begin
                    o_cmd.op = OP_FIN_SUM;
                    o_cmd.sel = DV_SPLT;
                    n_state = S_DIV;
                    n_red = 2'd2;
                    n_phase = PH_AG1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_AMUL: begin
                n_state = S_AG2;
            end
            S_AG2: begin
                if (!i_stat.ok) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_AVG_GCD2;
                    n_phase = PH_AG2;
                    n_state = S_RED;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // sum split finishes: capture it, then set up the average
        if (r_state == S_DIV && i_stat.div_done && r_red == 2'd2) begin
            o_cmd.op = OP_AVG_GCD1;
            if (i_stat.cnt_zero) begin
                n_state = S_OUT;
            end else begin
                n_state = S_RED;
                n_phase = PH_AG1;
            end
        end
        if (r_state == S_DIV && i_stat.div_done && r_red == 2'd0 && r_phase == PH_AVG) begin
            o_cmd.op = OP_NONE;
            n_state = S_OUT;
        end
    end
endmodule

// ----- hdl/mfsa_dp.sv -----
// ----------------------------------------------------------------------------
// mfsa_dp: arithmetic datapath
// A shared 32 x 32 multiplier, a 16 x 15 one, signed adder, restoring divider.
// ----------------------------------------------------------------------------
module mfsa_dp #(
    parameter int COUNT_BITS = 16,
    parameter int ACC_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfsa_pkg::t_in_item  i_item,
    input  mfsa_pkg::t_cmd      i_cmd,
    input  logic                i_out_take,
    output mfsa_pkg::t_stat     o_stat,
    output mfsa_pkg::t_out_item o_res
);
    import mfsa_pkg::*;

    localparam logic [63:0] LIM = 64'hFFFF_FFFF_FFFF_FFFF >> (65 - ACC_BITS);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic               r_rneg;
    logic [63:0]        r_rmag, r_rd;
    logic [COUNT_BITS-1:0] r_cnt;
    logic               r_ovf, r_zd, r_last, r_dz, r_ok;
    logic               r_vneg;
    logic [63:0]        r_vm, r_t1, r_t2, r_nd, r_sm;
    logic               r_sneg;
    logic [63:0]        r_a, r_b;     // gcd operands, a holds gcd when b==0
    logic [63:0]        r_x, r_y;     // values being reduced
    logic [63:0]        r_dn, r_dd, r_q, r_rem;
    logic [6:0]         r_dcnt;
    logic               r_dsel_y;
    logic               r_aovf;
    t_out_item          r_res;

    // 64 x 32 product on one 32 x 32 multiplier:
    // low half of the wide operand first, high half on the next cycle
    logic [63:0]  w_ma;
    logic [31:0]  w_mb;
    logic [63:0]  r_ma;
    logic [31:0]  r_mb;
    logic [63:0]  r_plo;
    t_op          r_mop;
    logic         r_mhi;
    logic [31:0]  w_mx, w_my;
    logic [63:0]  w_mp;
    logic [95:0]  w_prod;
    logic         w_pok;
    logic         w_mstart;
    logic [30:0]  w_vprod;
    always_comb begin
        case (i_cmd.op)
            OP_MUL2:    begin w_ma = r_rd; w_mb = r_vm[31:0]; end
            OP_MUL3:    begin w_ma = r_rd; w_mb = {17'd0, r_dd[14:0]}; end
            OP_AVG_MUL: begin w_ma = r_rd; w_mb = r_q[31:0]; end
            default:    begin w_ma = r_rmag; w_mb = {17'd0, r_dd[14:0]}; end
        endcase
    end
    assign w_mstart = (i_cmd.op == OP_MUL1) || (i_cmd.op == OP_MUL2) ||
                      (i_cmd.op == OP_MUL3) || (i_cmd.op == OP_AVG_MUL);
    assign w_mx   = r_mhi ? r_ma[63:32] : w_ma[31:0];
    assign w_my   = r_mhi ? r_mb : w_mb;
    assign w_mp   = w_mx * w_my;
    assign w_prod = {w_mp, 32'd0} + {32'd0, r_plo};
    assign w_pok  = (w_prod[95:64] == 32'd0) && (w_prod[63:0] <= LIM);
    assign w_vprod = r_vm[15:0] * r_dd[14:0];

    // divider step
    logic [64:0] w_trial;
    assign w_trial = {r_rem, r_dn[63]} - {1'b0, r_dd};

    assign o_stat.div_done = (r_dcnt == 7'd0);
    assign o_stat.b_zero   = (r_b == 64'd0);
    assign o_stat.ok       = r_ok;
    assign o_stat.last     = r_last;
    assign o_stat.dzero    = r_dz;
    assign o_stat.cnt_zero = (r_cnt == '0);

    logic [64:0] w_sum;
    assign w_sum = {1'b0, r_t1} + {1'b0, r_t2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rneg <= 1'b0; r_rmag <= '0; r_rd <= 64'd1; r_cnt <= '0;
            r_ovf <= 1'b0; r_zd <= 1'b0; r_dcnt <= '0;
            r_dsel_y <= 1'b0; r_mhi <= 1'b0; r_res <= '0;
        end else begin
            if (r_dcnt != 7'd0 && i_cmd.op == OP_DIV_STEP) begin
                r_dcnt <= r_dcnt - 7'd1;
                r_dn <= {r_dn[62:0], 1'b0};
                if (!w_trial[64]) begin
                    r_rem <= w_trial[63:0]; r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], r_dn[63]}; r_q <= {r_q[62:0], 1'b0};
                end
            end
            // start a product, or finish the one begun last cycle
            if (w_mstart) begin
                r_ma <= w_ma; r_mb <= w_mb; r_plo <= w_mp;
                r_mop <= i_cmd.op; r_mhi <= 1'b1;
            end else begin
                r_mhi <= 1'b0;
            end
            if (r_mhi) begin
                case (r_mop)
                    OP_MUL1: begin r_t1 <= w_prod[63:0]; r_ok <= w_pok; end
                    OP_MUL2: begin r_t2 <= w_prod[63:0]; r_ok <= r_ok & w_pok; end
                    OP_MUL3: begin r_nd <= w_prod[63:0]; r_ok <= r_ok & w_pok; end
                    OP_AVG_MUL: begin
                        r_ok <= w_pok; r_nd <= w_prod[63:0];
                        if (!w_pok) r_aovf <= 1'b1;
                    end
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_vneg <= i_item.whole_part[15];
                    r_vm <= {48'd0, (i_item.whole_part[15] ? -i_item.whole_part
                                                           : i_item.whole_part)};
                    r_dd <= {49'd0, i_item.frac_denominator};
                    r_dn <= {49'd0, i_item.frac_numerator};
                    r_last <= i_item.last_item;
                    r_dz <= (i_item.frac_denominator == 15'd0);
                    if (i_item.frac_denominator == 15'd0) r_zd <= 1'b1;
                    r_aovf <= 1'b0;
                end
                OP_MUL1: begin
                    r_vm <= {33'd0, w_vprod} + r_dn;
                end
                OP_ADD: begin
                    if (r_rneg == r_vneg) begin
                        r_sm <= w_sum[63:0]; r_sneg <= r_rneg;
                        if (w_sum[64] || w_sum[63:0] > LIM) r_ok <= 1'b0;
                    end else if (r_t1 >= r_t2) begin
                        r_sm <= r_t1 - r_t2; r_sneg <= r_rneg;
                    end else begin
                        r_sm <= r_t2 - r_t1; r_sneg <= r_vneg;
                    end
                end
                OP_GCD_INIT: begin
                    r_a <= r_sm; r_b <= r_nd; r_x <= r_sm; r_y <= r_nd;
                end
                OP_DIV_INIT: begin
                    r_dcnt <= 7'd64; r_rem <= '0; r_q <= '0;
                    if (i_cmd.sel == DV_GCD) begin
                        r_dn <= r_a; r_dd <= r_b;
                    end else if (r_dcnt == 7'd0 && r_dsel_y) begin
                        r_x <= r_q; r_dn <= r_y; r_dd <= (r_a == 0) ? 64'd1 : r_a;
                        r_dsel_y <= 1'b0;
                    end else begin
                        r_dn <= r_x; r_dd <= (r_a == 0) ? 64'd1 : r_a;
                        r_dsel_y <= 1'b1;
                    end
                end
                OP_GCD_NEXT: begin r_a <= r_b; r_b <= r_rem; end
                OP_COMMIT: begin
                    if (r_dz) begin
                    end else if (!r_ok) r_ovf <= 1'b1;
                    else begin
                        r_rmag <= r_x; r_rd <= r_q;
                        r_rneg <= r_sneg && (r_x != 0);
                        if (r_cnt != CMAX) r_cnt <= r_cnt + 1'b1;
                        else r_ovf <= 1'b1;
                    end
                end
                OP_FIN_SUM: begin
                    r_dcnt <= 7'd64; r_rem <= '0; r_q <= '0;
                    r_dn <= r_rmag; r_dd <= r_rd;
                end
                OP_AVG_GCD1: begin
                    r_res.sum_whole <= r_rneg ? -r_q : r_q;
                    r_res.sum_remainder <= r_rneg ? -r_rem : r_rem;
                    r_res.sum_denom <= r_rd[62:0];
                    r_a <= r_rmag; r_b <= {{(64-COUNT_BITS){1'b0}}, r_cnt};
                    r_x <= r_rmag; r_y <= {{(64-COUNT_BITS){1'b0}}, r_cnt};
                end
                OP_AVG_MUL: begin
                    r_sm <= r_x;
                end
                OP_AVG_GCD2: begin
                    r_a <= r_sm; r_b <= r_nd; r_x <= r_sm; r_y <= r_nd;
                end
                OP_FIN_AVG: begin
                    r_sm <= r_x; r_nd <= r_q;
                    r_dcnt <= 7'd64; r_rem <= '0; r_q <= '0;
                    r_dn <= r_x; r_dd <= r_q;
                end
                default: ;
            endcase
            if (i_out_take) begin
                r_rneg <= 1'b0; r_rmag <= '0; r_rd <= 64'd1; r_cnt <= '0;
                r_ovf <= 1'b0; r_zd <= 1'b0;
            end
        end
    end

    // output fields assembled from the finished splits
    always_comb begin
        o_res = r_res;
        o_res.overflow_flag = r_ovf | r_aovf;
        o_res.bad_denominator_flag = r_zd;
        if (r_cnt == '0 || r_aovf) begin
            o_res.avg_whole = '0; o_res.avg_remainder = '0; o_res.avg_denom = 63'd1;
        end else begin
            o_res.avg_whole = (r_rneg && r_sm != 0) ? -r_q : r_q;
            o_res.avg_remainder = (r_rneg && r_sm != 0) ? -r_rem : r_rem;
            o_res.avg_denom = r_nd[62:0];
        end
    end
endmodule

// ----- hdl/mixed_fraction_sum_average.sv -----
// ----------------------------------------------------------------------------
// mixed_fraction_sum_average: exact fraction accumulator
// Sums mixed fractions, reduces by gcd and reports sum and average.
// ----------------------------------------------------------------------------
// One request enters when the block is idle. Each of the three products runs
// as a low and a high half on the shared 32 x 32 multiplier, followed by the
// add and gcd setup. The Euclid gcd then runs one restoring division per
// remainder, and the two reducing divisions follow. A zero denominator ends
// the item before any product, an overflow at gcd setup. The last item adds
// a sum split, an average gcd, a product, a second gcd and the average split.
module mixed_fraction_sum_average #(
    parameter int COUNT_BITS = mfsa_pkg::COUNT_BITS_DEF,
    parameter int ACC_BITS   = mfsa_pkg::ACC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mfsa_stream_if.sink   i_in,
    mfsa_stream_if.source o_out
);
    import mfsa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    t_out_item w_res;

    // sequence the work
    mfsa_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    // hold the arithmetic
    mfsa_dp #(.COUNT_BITS(COUNT_BITS), .ACC_BITS(ACC_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_item(i_in.data), .i_cmd(w_cmd),
        .i_out_take(o_out.valid & o_out.ready),
        .o_stat(w_stat), .o_res(w_res)
    );

    assign o_out.data = w_res;

    // no request is taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("accept during output");
    // a result leaves the block idle next cycle
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> i_in.ready) else $error("no return to idle");
endmodule
